>>> rtl/core/polar_height_descriptor_builder_top_defines.svh
// Assertion helpers for the checker file.
`ifndef POLAR_HEIGHT_DESCRIPTOR_BUILDER_TOP_DEFINES_SVH
`define POLAR_HEIGHT_DESCRIPTOR_BUILDER_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PHDB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define PHDB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

>>> rtl/core/phdb_pkg.sv
`default_nettype none
package phdb_pkg;

  localparam int NumRingsDef   = 20;
  localparam int NumSectorsDef = 60;
  localparam int CoordBitsDef  = 16;

  localparam int HeightW     = 16;
  localparam int MaxRadiusW  = 15;
  localparam int IdxMaxW     = 14;
  localparam int FifoDepth   = 4;
  localparam int CordicSteps = 32;
  localparam int CordicW     = 52;
  localparam int AngleW      = 32;

  localparam logic [MaxRadiusW-1:0] MaxRadiusRst    = 15'd20480;
  localparam logic [HeightW-1:0]    SensorHeightRst = 16'd0;

  // Register select is address bit 2.
  localparam logic REG_MAX_RADIUS    = 1'b0;
  localparam logic REG_SENSOR_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_READ,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                       op;
    logic                      in_grid;
    logic [IdxMaxW-1:0]        idx;
    logic signed [HeightW-1:0] height;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_MAG,
    F_SQR,
    F_SUM,
    F_LIM,
    F_RING,
    F_ANG,
    F_SEC,
    F_IDX,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_UPD,
    B_RES,
    B_CLR
  } back_state_e;

  // atan(2^-i) in units of 2^-32 of a full turn.
  function automatic logic [AngleW-1:0] atan_turn(input logic [4:0] i);
    logic [AngleW-1:0] t;
    case (i)
      5'd0:  t = 32'd536870912;
      5'd1:  t = 32'd316933406;
      5'd2:  t = 32'd167458907;
      5'd3:  t = 32'd85004756;
      5'd4:  t = 32'd42667331;
      5'd5:  t = 32'd21354465;
      5'd6:  t = 32'd10679838;
      5'd7:  t = 32'd5340245;
      5'd8:  t = 32'd2670163;
      5'd9:  t = 32'd1335087;
      5'd10: t = 32'd667544;
      5'd11: t = 32'd333772;
      5'd12: t = 32'd166886;
      5'd13: t = 32'd83443;
      5'd14: t = 32'd41722;
      5'd15: t = 32'd20861;
      5'd16: t = 32'd10430;
      5'd17: t = 32'd5215;
      5'd18: t = 32'd2608;
      5'd19: t = 32'd1304;
      5'd20: t = 32'd652;
      5'd21: t = 32'd326;
      5'd22: t = 32'd163;
      5'd23: t = 32'd81;
      5'd24: t = 32'd41;
      5'd25: t = 32'd20;
      5'd26: t = 32'd10;
      5'd27: t = 32'd5;
      5'd28: t = 32'd3;
      5'd29: t = 32'd1;
      5'd30: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/phdb_ram.sv
`default_nettype none
module phdb_ram #(
  parameter int Width = 17,
  parameter int Depth = 1200,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AddrW-1:0]      waddr_i,
  input  wire logic [Width-1:0]      wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AddrW-1:0]      raddr_i,
  output logic      [Width-1:0]      rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/phdb_fifo.sv
`default_nettype none
module phdb_fifo
  import phdb_pkg::*;
#(
  parameter int Depth = FifoDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire q_entry_t  entry_i,
  input  wire logic      pop_i,
  output q_entry_t       entry_o,
  output q_status_t      status_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  q_entry_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign entry_o        = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/phdb_front.sv
`default_nettype none
module phdb_front
  import phdb_pkg::*;
#(
  parameter int NumRings   = NumRingsDef,
  parameter int NumSectors = NumSectorsDef,
  parameter int CoordBits  = CoordBitsDef,
  parameter int RingSelW   = 5,
  parameter int SecSelW    = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic signed [CoordBits-1:0] pos_x_i,
  input  wire logic signed [CoordBits-1:0] pos_y_i,
  input  wire logic signed [CoordBits-1:0] pos_z_i,
  input  wire logic [RingSelW-1:0]         ring_sel_i,
  input  wire logic [SecSelW-1:0]          sector_sel_i,
  input  wire logic [MaxRadiusW-1:0]       max_radius_i,
  input  wire logic signed [HeightW-1:0]   sensor_height_i,
  input  wire q_status_t                   q_status_i,
  output logic                             push_o,
  output q_entry_t                         entry_o,
  output logic                             idle_o
);
  localparam int SqW   = 2 * CoordBits;
  localparam int M2W   = 2 * MaxRadiusW;
  localparam int LimW  = ((SqW > M2W) ? SqW : M2W) + 13;
  localparam int KW    = $clog2(NumRings + 1);
  localparam int SecW  = $clog2(NumSectors + 1);
  localparam int ProdW = AngleW + SecW;
  localparam int ZW    = ((CoordBits > HeightW) ? CoordBits : HeightW) + 1;
  localparam int PreShift = 48 - CoordBits;

  localparam logic signed [ZW-1:0] HMax = ZW'(32767);
  localparam logic signed [ZW-1:0] HMin = -ZW'(32768);

  front_state_e state_q, state_d;

  logic signed [CoordBits-1:0] x_q, y_q, z_q;
  logic [CoordBits-1:0]        ax_q, ay_q;
  logic signed [HeightW-1:0]   h_q;
  logic [SqW-1:0]              sqx_q, sqy_q, s_q;
  logic [M2W-1:0]              m2_q;
  logic [LimW-1:0]             lim_q, acc_q, dd_q;
  logic [KW-1:0]               k_q, ring_q;
  logic signed [CordicW-1:0]   cx_q, cy_q;
  logic [AngleW-1:0]           ang_q;
  logic [4:0]                  step_q;
  logic                        axis_q;
  logic [ProdW-1:0]            prod_q;
  q_entry_t                    entry_q;

  logic signed [ZW-1:0]        zsum;
  logic signed [CordicW-1:0]   cx0, cy0, dx, dy;
  logic [SecW-1:0]             sec_raw, sec_cl;
  logic                        ring_hit;

  assign idle_o  = (state_q == F_IDLE);
  assign push_o  = (state_q == F_PUSH) && !q_status_i.full;
  assign entry_o = entry_q;

  assign zsum     = ZW'(z_q) + ZW'(sensor_height_i);
  assign cx0      = CordicW'(x_q) <<< PreShift;
  assign cy0      = CordicW'(y_q) <<< PreShift;
  assign dx       = cy_q >>> step_q;
  assign dy       = cx_q >>> step_q;
  assign ring_hit = (acc_q >= lim_q);
  assign sec_raw  = SecW'((prod_q + ProdW'(32'hFFFF_FFFF)) >> AngleW);

  always_comb begin
    if (sec_raw == '0) begin
      sec_cl = SecW'(1);
    end else if (sec_raw > SecW'(NumSectors)) begin
      sec_cl = SecW'(NumSectors);
    end else begin
      sec_cl = sec_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept_i) begin
          case (cmd_i)
            CMD_ADD:   state_d = F_MAG;
            CMD_READ:  state_d = F_PUSH;
            CMD_CLEAR: state_d = F_PUSH;
            default:   state_d = F_IDLE;
          endcase
        end
      end
      F_MAG: state_d = F_SQR;
      F_SQR: state_d = F_SUM;
      F_SUM: state_d = F_LIM;
      F_LIM: begin
        state_d = (LimW'(s_q) > LimW'(m2_q)) ? F_IDLE : F_RING;
      end
      F_RING: begin
        if (ring_hit) begin
          state_d = axis_q ? F_SEC : F_ANG;
        end
      end
      F_ANG: begin
        if (step_q == 5'(CordicSteps - 1)) begin
          state_d = F_SEC;
        end
      end
      F_SEC:  state_d = F_IDX;
      F_IDX:  state_d = F_PUSH;
      F_PUSH: begin
        if (!q_status_i.full) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        x_q <= pos_x_i;
        y_q <= pos_y_i;
        z_q <= pos_z_i;
        entry_q.in_grid <= (32'(ring_sel_i) < NumRings) && (32'(sector_sel_i) < NumSectors);
        entry_q.idx     <= IdxMaxW'(ring_sel_i) * IdxMaxW'(NumSectors)
                           + IdxMaxW'(sector_sel_i);
        entry_q.height  <= '0;
        entry_q.op      <= (cmd_i == CMD_CLEAR) ? OP_CLEAR : OP_READ;
      end
      F_MAG: begin
        ax_q <= x_q[CoordBits-1] ? CoordBits'(-x_q) : CoordBits'(x_q);
        ay_q <= y_q[CoordBits-1] ? CoordBits'(-y_q) : CoordBits'(y_q);
        if (zsum > HMax) begin
          h_q <= HeightW'(HMax);
        end else if (zsum < HMin) begin
          h_q <= HeightW'(HMin);
        end else begin
          h_q <= HeightW'(zsum);
        end
      end
      F_SQR: begin
        sqx_q <= SqW'(ax_q) * SqW'(ax_q);
        sqy_q <= SqW'(ay_q) * SqW'(ay_q);
        m2_q  <= M2W'(max_radius_i) * M2W'(max_radius_i);
      end
      F_SUM: begin
        s_q <= sqx_q + sqy_q;
      end
      F_LIM: begin
        lim_q  <= LimW'(s_q) * LimW'(NumRings * NumRings);
        acc_q  <= LimW'(m2_q);
        dd_q   <= LimW'(m2_q) * LimW'(3);
        k_q    <= KW'(1);
        step_q <= '0;
        // Points on an axis get their angle directly.
        if (y_q == '0) begin
          axis_q <= 1'b1;
          ang_q  <= x_q[CoordBits-1] ? 32'h8000_0000 : 32'h0;
        end else if (x_q == '0) begin
          axis_q <= 1'b1;
          ang_q  <= y_q[CoordBits-1] ? 32'hC000_0000 : 32'h4000_0000;
        end else begin
          axis_q <= 1'b0;
          if (x_q[CoordBits-1]) begin
            cx_q  <= -cx0;
            cy_q  <= -cy0;
            ang_q <= 32'h8000_0000;
          end else begin
            cx_q  <= cx0;
            cy_q  <= cy0;
            ang_q <= 32'h0;
          end
        end
      end
      F_RING: begin
        if (ring_hit) begin
          ring_q <= k_q;
        end else begin
          acc_q <= acc_q + dd_q;
          dd_q  <= dd_q + (LimW'(m2_q) << 1);
          k_q   <= k_q + KW'(1);
        end
      end
      F_ANG: begin
        if (!cy_q[CordicW-1]) begin
          cx_q  <= cx_q + dx;
          cy_q  <= cy_q - dy;
          ang_q <= ang_q + atan_turn(step_q);
        end else begin
          cx_q  <= cx_q - dx;
          cy_q  <= cy_q + dy;
          ang_q <= ang_q - atan_turn(step_q);
        end
        step_q <= step_q + 5'd1;
      end
      F_SEC: begin
        prod_q <= ProdW'(ang_q) * ProdW'(NumSectors);
      end
      F_IDX: begin
        entry_q.op      <= OP_ADD;
        entry_q.in_grid <= 1'b1;
        entry_q.height  <= h_q;
        entry_q.idx     <= (IdxMaxW'(ring_q) - IdxMaxW'(1)) * IdxMaxW'(NumSectors)
                           + IdxMaxW'(sec_cl) - IdxMaxW'(1);
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/core/phdb_back.sv
`default_nettype none
module phdb_back
  import phdb_pkg::*;
#(
  parameter int NumRings   = NumRingsDef,
  parameter int NumSectors = NumSectorsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire q_status_t                 q_status_i,
  input  wire q_entry_t                  entry_i,
  output logic                           pop_o,
  output logic                           init_done_o,
  output logic                           result_valid_o,
  output logic signed [HeightW-1:0]      bin_height_o,
  output logic                           bin_occupied_o
);
  localparam int Bins  = NumRings * NumSectors;
  localparam int IdxW  = (Bins > 1) ? $clog2(Bins) : 1;
  localparam int WordW = HeightW + 1;

  back_state_e state_q, state_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  q_entry_t         cur_q;

  logic                      we, re;
  logic [IdxW-1:0]           waddr, raddr;
  logic [WordW-1:0]          wdata, rdata;
  logic                      res_valid_d, res_occ_d;
  logic signed [HeightW-1:0] res_h_d;
  logic                      res_valid_q, res_occ_q;
  logic signed [HeightW-1:0] res_h_q;

  // Each word holds the occupied mark above the height; a cleared word is all zero.
  phdb_ram #(
    .Width (WordW),
    .Depth (Bins)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign init_done_o    = (state_q != B_INIT);
  assign result_valid_o = res_valid_q;
  assign bin_height_o   = res_h_q;
  assign bin_occupied_o = res_occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_INIT;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
    res_h_q   <= res_h_d;
    res_occ_q <= res_occ_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = cnt_q;
    wdata       = '0;
    re          = 1'b0;
    raddr       = IdxW'(entry_i.idx);
    res_valid_d = 1'b0;
    res_h_d     = '0;
    res_occ_d   = 1'b0;
    case (state_q)
      B_INIT, B_CLR: begin
        we = 1'b1;
        if (cnt_q == IdxW'(Bins - 1)) begin
          cnt_d   = '0;
          state_d = B_IDLE;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      B_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          case (entry_i.op)
            OP_ADD: begin
              re      = 1'b1;
              state_d = B_UPD;
            end
            OP_READ: begin
              if (entry_i.in_grid) begin
                re      = 1'b1;
                state_d = B_RES;
              end else begin
                res_valid_d = 1'b1;
              end
            end
            OP_CLEAR: begin
              cnt_d   = '0;
              state_d = B_CLR;
            end
            default: state_d = B_IDLE;
          endcase
        end
      end
      B_UPD: begin
        waddr = IdxW'(cur_q.idx);
        wdata = {1'b1, cur_q.height};
        if (!rdata[HeightW] || (cur_q.height > $signed(rdata[HeightW-1:0]))) begin
          we = 1'b1;
        end
        state_d = B_IDLE;
      end
      B_RES: begin
        res_valid_d = 1'b1;
        res_h_d     = $signed(rdata[HeightW-1:0]);
        res_occ_d   = rdata[HeightW];
        state_d     = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/core/polar_height_descriptor_builder_top.sv
`default_nettype none
// Polar ring-by-sector map of maximum point height.
// Requests enter on start/cmd_i with the point or bin fields; one is taken at an edge
// with start high and busy low. cmd_i selects add point, read bin or clear all bins;
// code 3 is ignored. Only a read gives a result: result_valid_o is high for one cycle
// with bin_height_o and bin_occupied_o, and the receiver cannot hold it off.
// An add keeps busy high while the front sequencer works on it: the ring is found by a
// search of one ring per cycle and the angle by a 32-step CORDIC iteration, both in
// the front sequencer. Points on an axis skip the CORDIC steps, and a point beyond
// max_radius returns the front to idle from the limit check without queueing it.
// A read or clear goes straight from idle to the queue push, and busy stays high
// while the queue is full. Requests then pass through a four-entry queue to the
// back end, which does one read-modify-write of the bin RAM per add; a read result
// is registered after the bin RAM read that follows its leaving the queue.
// A clear sweeps the bin RAM at one bin per cycle over all NUM_RINGS*NUM_SECTORS
// bins (1200 by default) in the back end while the front keeps taking requests.
// After reset the same sweep runs with busy held high until it ends; registers
// return to max_radius 80 m and sensor_height 0 and stay writable over APB.
module polar_height_descriptor_builder_top
  import phdb_pkg::*;
#(
  parameter int NUM_RINGS   = NumRingsDef,
  parameter int NUM_SECTORS = NumSectorsDef,
  parameter int COORD_BITS  = CoordBitsDef,
  localparam int RingSelW   = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1,
  localparam int SecSelW    = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   cmd_i,
  input  wire logic signed [COORD_BITS-1:0] pos_x_i,
  input  wire logic signed [COORD_BITS-1:0] pos_y_i,
  input  wire logic signed [COORD_BITS-1:0] pos_z_i,
  input  wire logic [RingSelW-1:0]          ring_sel_i,
  input  wire logic [SecSelW-1:0]           sector_sel_i,
  output logic                              result_valid_o,
  output logic signed [HeightW-1:0]         bin_height_o,
  output logic                              bin_occupied_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  logic [MaxRadiusW-1:0]     max_radius_q;
  logic signed [HeightW-1:0] sensor_height_q;
  logic                      cfg_wr, accept, front_idle, init_done, push, pop;
  q_entry_t                  push_entry, head_entry;
  q_status_t                 q_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign busy   = !(front_idle && init_done);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_radius_q    <= MaxRadiusRst;
      sensor_height_q <= SensorHeightRst;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_RADIUS) begin
        max_radius_q <= pwdata[MaxRadiusW-1:0];
      end else begin
        sensor_height_q <= pwdata[HeightW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SENSOR_HEIGHT) ? 32'(sensor_height_q)
                                                  : 32'(max_radius_q);

  phdb_front #(
    .NumRings   (NUM_RINGS),
    .NumSectors (NUM_SECTORS),
    .CoordBits  (COORD_BITS),
    .RingSelW   (RingSelW),
    .SecSelW    (SecSelW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .cmd_i           (cmd_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .ring_sel_i      (ring_sel_i),
    .sector_sel_i    (sector_sel_i),
    .max_radius_i    (max_radius_q),
    .sensor_height_i (sensor_height_q),
    .q_status_i      (q_status),
    .push_o          (push),
    .entry_o         (push_entry),
    .idle_o          (front_idle)
  );

  phdb_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (q_status)
  );

  phdb_back #(
    .NumRings   (NUM_RINGS),
    .NumSectors (NUM_SECTORS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .entry_i        (head_entry),
    .pop_o          (pop),
    .init_done_o    (init_done),
    .result_valid_o (result_valid_o),
    .bin_height_o   (bin_height_o),
    .bin_occupied_o (bin_occupied_o)
  );
endmodule
`default_nettype wire

>>> rtl/core/phdb_checker.sv
`default_nettype none
`include "polar_height_descriptor_builder_top_defines.svh"
module phdb_checker
  import phdb_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic [1:0]                cmd_i,
  input wire logic                      result_valid_o,
  input wire logic signed [HeightW-1:0] bin_height_o,
  input wire logic                      bin_occupied_o
);
  // Busy is high throughout reset, since the bin RAM is swept clean right after it.
  `PHDB_ASSERT_ALWAYS(a_busy_in_reset, clk_i, !rst_ni |-> busy)

  // Any real command keeps the block busy for at least the next cycle.
  `PHDB_ASSERT(a_busy_after_req, clk_i, rst_ni, start && !busy && cmd_i != CMD_NOP |=> busy)

  // An empty bin always reads as height zero.
  `PHDB_ASSERT(a_empty_zero, clk_i, rst_ni, result_valid_o && !bin_occupied_o |-> bin_height_o == '0)
endmodule

bind polar_height_descriptor_builder_top phdb_checker u_phdb_checker (.*);
`default_nettype wire
